// ===== rtl/core/uyvy422_to_yuv420_converter_top_assert.svh =====
// Assertion macros for the UYVY to 4:2:0 converter checker.
// Depends on nothing; included by the checker file only.
`ifndef UYVY422_TO_YUV420_CONVERTER_TOP_ASSERT_SVH
`define UYVY422_TO_YUV420_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define UYV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uyv converter: same-cycle check failed");

// Next-cycle implication, quiet while reset is high.
`define UYV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uyv converter: next-cycle check failed");

`endif

// ===== rtl/core/uyv_pkg.sv =====
// Shared constants and types for the UYVY 4:2:2 to 4:2:0 converter.
// No dependencies; used by uyv_position, uyv_out_stage and the converter top.
package uyv_pkg;

   localparam int MAX_PAIRS    = 1024;
   localparam int COL_W        = $clog2(MAX_PAIRS);
   localparam int CFG_W        = 11;
   localparam int PAIR_COL_W   = 10;
   localparam int CMP_W        = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
   localparam int CHROMA_W     = 16;
   localparam logic [CFG_W-1:0] PAIRS_PER_ROW_RESET = CFG_W'(320);

   // Position of the item being accepted.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             odd;
      logic             last;
   } pos_type;

   // Word held between the line store access and the result register.
   typedef struct packed {
      logic [7:0]       luma_first;
      logic [7:0]       luma_second;
      logic [7:0]       u;
      logic [7:0]       v;
      logic [COL_W-1:0] col;
      logic             odd;
      logic             last;
   } stage_type;

   function automatic logic [7:0] round_avg(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b} + 9'd1;
      return sum[8:1];
   endfunction

endpackage

// ===== rtl/core/uyv_req_if.sv =====
// Input channel: one UYVY pixel pair per word with valid/ready.
// Depends on nothing.
interface uyv_req_if;
   logic       valid;
   logic       ready;
   logic       frame_start;
   logic [7:0] u_in;
   logic [7:0] luma_first_in;
   logic [7:0] v_in;
   logic [7:0] luma_second_in;

   modport source (output valid, frame_start, u_in, luma_first_in, v_in, luma_second_in,
                   input ready);
   modport sink   (input valid, frame_start, u_in, luma_first_in, v_in, luma_second_in,
                   output ready);
endinterface

// ===== rtl/core/uyv_rsp_if.sv =====
// Result channel: luma pair, averaged chroma and position per word.
// Depends on nothing.
interface uyv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_first_out;
   logic [7:0] luma_second_out;
   logic [7:0] chroma_u_out;
   logic [7:0] chroma_v_out;
   logic       chroma_valid;
   logic [9:0] pair_column;
   logic       row_is_odd;
   logic       row_end;

   modport source (output valid, luma_first_out, luma_second_out, chroma_u_out,
                   chroma_v_out, chroma_valid, pair_column, row_is_odd, row_end,
                   input ready);
   modport sink   (input valid, luma_first_out, luma_second_out, chroma_u_out,
                   chroma_v_out, chroma_valid, pair_column, row_is_odd, row_end,
                   output ready);
endinterface

// ===== rtl/core/uyv_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module uyv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/uyv_position.sv =====
// Row length register plus column counter and row parity tracking.
// Depends on uyv_pkg.
module uyv_position (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [uyv_pkg::CFG_W-1:0] csr_wr_data,
   input  logic                      advance,
   input  logic                      frame_start,
   output uyv_pkg::pos_type          pos
);
   logic [uyv_pkg::CFG_W-1:0] ppr_ff;
   logic [uyv_pkg::COL_W-1:0] col_ff, col_in, cur_col;
   logic                      odd_ff, odd_in, cur_odd;
   logic [uyv_pkg::CMP_W-1:0] cfg_ext, last_col;
   logic                      last;

   always_comb begin
      cfg_ext = uyv_pkg::CMP_W'(ppr_ff);
      // zero length acts as one, oversize clamps to the store depth
      if (ppr_ff == '0) begin
         last_col = '0;
      end else if (cfg_ext > uyv_pkg::CMP_W'(uyv_pkg::MAX_PAIRS)) begin
         last_col = uyv_pkg::CMP_W'(uyv_pkg::MAX_PAIRS - 1);
      end else begin
         last_col = cfg_ext - uyv_pkg::CMP_W'(1);
      end
   end

   assign cur_col = frame_start ? '0 : col_ff;
   assign cur_odd = frame_start ? 1'b0 : odd_ff;
   assign last    = (uyv_pkg::CMP_W'(cur_col) >= last_col);

   always_comb begin
      col_in = col_ff;
      odd_in = odd_ff;
      if (advance) begin
         if (last) begin
            col_in = '0;
            odd_in = ~cur_odd;
         end else begin
            col_in = cur_col + uyv_pkg::COL_W'(1);
            odd_in = cur_odd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff <= uyv_pkg::PAIRS_PER_ROW_RESET;
         col_ff <= '0;
         odd_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ppr_ff <= csr_wr_data;
         end
         col_ff <= col_in;
         odd_ff <= odd_in;
      end
   end

   assign pos.col  = cur_col;
   assign pos.odd  = cur_odd;
   assign pos.last = last;
endmodule

// ===== rtl/core/uyv_out_stage.sv =====
// Chroma averaging and the result register that drives the output channel.
// Depends on uyv_pkg and uyv_rsp_if.
module uyv_out_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         stage_valid,
   input  uyv_pkg::stage_type           stage,
   input  logic [uyv_pkg::CHROMA_W-1:0] stored_chroma,
   output logic                         stage_go,
   uyv_rsp_if.source                    rsp_chan
);
   logic       out_valid_ff, out_valid_in;
   logic       load;
   logic [7:0] luma_first_ff, luma_second_ff, cu_ff, cv_ff, cu_in, cv_in;
   logic [9:0] column_ff;
   logic       odd_ff, last_ff;

   assign stage_go     = ~out_valid_ff | rsp_chan.ready;
   assign load         = stage_valid & stage_go;
   assign out_valid_in = load | (out_valid_ff & ~rsp_chan.ready);

   always_comb begin
      cu_in = '0;
      cv_in = '0;
      // odd rows: average against the even-row pair held in the line store
      if (stage.odd) begin
         cu_in = uyv_pkg::round_avg(stored_chroma[7:0], stage.u);
         cv_in = uyv_pkg::round_avg(stored_chroma[15:8], stage.v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         luma_first_ff  <= stage.luma_first;
         luma_second_ff <= stage.luma_second;
         cu_ff          <= cu_in;
         cv_ff          <= cv_in;
         column_ff      <= uyv_pkg::PAIR_COL_W'(stage.col);
         odd_ff         <= stage.odd;
         last_ff        <= stage.last;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.luma_first_out  = luma_first_ff;
   assign rsp_chan.luma_second_out = luma_second_ff;
   assign rsp_chan.chroma_u_out    = cu_ff;
   assign rsp_chan.chroma_v_out    = cv_ff;
   assign rsp_chan.chroma_valid    = odd_ff;
   assign rsp_chan.pair_column     = column_ff;
   assign rsp_chan.row_is_odd      = odd_ff;
   assign rsp_chan.row_end         = last_ff;
endmodule

// ===== rtl/core/uyvy422_to_yuv420_converter_top.sv =====
// Channel   Direction  Carries
// req_chan  in         frame_start, U, left luma, V, right luma (one pixel pair)
// rsp_chan  out        both lumas, averaged U/V, chroma_valid, column, parity, row_end
// csr       in         pairs_per_row write (csr_wr_en, csr_wr_data)
//
// One word per cycle sustained while rsp_chan is not stalled; an accepted word is registered
// into the stage register along with the line store read, then averaged into the result register.
// Reset is synchronous; it clears the position, the row length (to 320) and the
// pipeline valids. The line store is not cleared. A stalled rsp_chan backs up
// through the single stage register into req_chan.ready.
// Depends on uyv_pkg, uyv_req_if, uyv_rsp_if, uyv_ram, uyv_position, uyv_out_stage.
module uyvy422_to_yuv420_converter_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [uyv_pkg::CFG_W-1:0] csr_wr_data,
   uyv_req_if.sink                   req_chan,
   uyv_rsp_if.source                 rsp_chan
);
   uyv_pkg::pos_type             pos;
   uyv_pkg::stage_type           stage_ff, stage_in;
   logic                         stage_valid_ff, stage_valid_in;
   logic                         stage_go;
   logic                         accept;
   logic [uyv_pkg::CHROMA_W-1:0] stored_chroma;

   assign req_chan.ready = ~stage_valid_ff | stage_go;
   assign accept         = req_chan.valid & req_chan.ready;

   uyv_position u_position (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (accept),
      .frame_start (req_chan.frame_start),
      .pos         (pos)
   );

   // even rows write the pair's chroma, odd rows read it back
   uyv_ram #(
      .WIDTH (uyv_pkg::CHROMA_W),
      .DEPTH (uyv_pkg::MAX_PAIRS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept & ~pos.odd),
      .wr_addr (pos.col),
      .wr_data ({req_chan.v_in, req_chan.u_in}),
      .rd_en   (accept & pos.odd),
      .rd_addr (pos.col),
      .rd_data (stored_chroma)
   );

   always_comb begin
      stage_in.luma_first  = req_chan.luma_first_in;
      stage_in.luma_second = req_chan.luma_second_in;
      stage_in.u           = req_chan.u_in;
      stage_in.v           = req_chan.v_in;
      stage_in.col         = pos.col;
      stage_in.odd         = pos.odd;
      stage_in.last        = pos.last;
   end

   assign stage_valid_in = accept | (stage_valid_ff & ~stage_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   uyv_out_stage u_out_stage (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid_ff),
      .stage         (stage_ff),
      .stored_chroma (stored_chroma),
      .stage_go      (stage_go),
      .rsp_chan      (rsp_chan)
   );
endmodule

// ===== rtl/core/uyv_checker.sv =====
// Port-level checker for the converter top, attached by the bind below.
// Depends on uyvy422_to_yuv420_converter_top_assert.svh and the top level.
`include "uyvy422_to_yuv420_converter_top_assert.svh"

module uyv_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_luma_first,
   input logic [7:0] rsp_chroma_u,
   input logic [7:0] rsp_chroma_v,
   input logic       rsp_chroma_valid,
   input logic       rsp_row_is_odd
);
   // chroma carries a sample exactly on odd rows
   `UYV_ASSERT_NOW(chroma_on_odd_rows, clock, reset, rsp_valid, rsp_chroma_valid == rsp_row_is_odd)
   // even rows leave chroma at zero
   `UYV_ASSERT_NOW(even_row_chroma_zero, clock, reset, rsp_valid && !rsp_chroma_valid, rsp_chroma_u == 8'd0 && rsp_chroma_v == 8'd0)
   `UYV_ASSERT_NEXT(stalled_word_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_luma_first) && $stable(rsp_chroma_u))
endmodule

bind uyvy422_to_yuv420_converter_top uyv_checker u_uyv_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_luma_first   (rsp_chan.luma_first_out),
   .rsp_chroma_u     (rsp_chan.chroma_u_out),
   .rsp_chroma_v     (rsp_chan.chroma_v_out),
   .rsp_chroma_valid (rsp_chan.chroma_valid),
   .rsp_row_is_odd   (rsp_chan.row_is_odd)
);
